/* rtl/cpp_pkg.sv */
// ----------------------------------------------------------------------------
// cpp_pkg - shared types and constants for the camera projection pipeline
// Widths of the rotated coordinates, the wide products and the quotient,
// register indexes, depth status codes and the per-item sideband.
// ----------------------------------------------------------------------------
package cpp_pkg;

  localparam int COORD_W = 38;  // rotated camera-space coordinate, signed Q22.16
  localparam int RES_W   = 13;  // screen resolution, up to 8191
  localparam int SCALE_W = 44;  // resolution * focal length
  localparam int VIEW_W  = 31;  // view plane size / focal length
  localparam int NUM_W   = COORD_W + SCALE_W;  // 82
  localparam int DEN_W   = COORD_W + VIEW_W;   // 69
  localparam int Q_W     = 22;                 // quotient bits kept
  localparam int CMP_W   = DEN_W + Q_W;        // widest trial divisor

  // operand split points for the partial products
  localparam int MAG_LO   = 19;
  localparam int SCALE_LO = 22;
  localparam int VIEW_LO  = 16;

  localparam logic [Q_W-1:0] QLIMIT = Q_W'(32'h0010_0000);

  localparam int ROT_LAT  = 5;
  localparam int MUL_LAT  = 3;
  localparam int DIV_LAT  = Q_W + 1;
  localparam int PIPE_LAT = ROT_LAT + MUL_LAT + DIV_LAT + 1;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_X   = 3'd0,
    CFG_CAM_Y   = 3'd1,
    CFG_CAM_Z   = 3'd2,
    CFG_TRIG    = 3'd3,
    CFG_VIEW_W  = 3'd4,
    CFG_VIEW_H  = 3'd5,
    CFG_FOCAL   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_FRONT  = 2'd0,
    ST_ZERO   = 2'd1,
    ST_BEHIND = 2'd2
  } depth_status_t;

  typedef struct packed {
    logic pos_x;    // result x lies right of centre
    logic pos_y;    // result y lies above centre (after flip)
    logic dz_zero;
    logic dz_neg;
  } side_t;

endpackage

/* rtl/cpp_rotate.sv */
// ----------------------------------------------------------------------------
// cpp_rotate - translate and rotate one vertex into camera space
// Five stages: subtract camera, yaw products, yaw sums, pitch products,
// pitch sums. Each sum drops 14 fraction bits with a floor shift.
// ----------------------------------------------------------------------------
module cpp_rotate (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [31:0]                 vertex_x,
  input  logic signed [31:0]                 vertex_y,
  input  logic signed [31:0]                 vertex_z,
  input  logic signed [31:0]                 cam_x,
  input  logic signed [31:0]                 cam_y,
  input  logic signed [31:0]                 cam_z,
  input  logic [63:0]                        trig,
  output logic signed [cpp_pkg::COORD_W-1:0] dx,
  output logic signed [cpp_pkg::COORD_W-1:0] dy,
  output logic signed [cpp_pkg::COORD_W-1:0] dz
);

  logic signed [15:0] sp, cp, sy, cy;
  assign sp = trig[63:48];
  assign cp = trig[47:32];
  assign sy = trig[31:16];
  assign cy = trig[15:0];

  logic signed [32:0] x1, y1, z1, y2, y3;
  logic signed [48:0] p_cyx, p_syz, p_cyz, p_syx;
  logic signed [49:0] s_dx, s_t;
  logic signed [35:0] dx3, t3, dx4;
  logic signed [51:0] r_spt, r_cpy, r_cpt, r_spy;
  logic signed [51:0] s_dy, s_dz;

  assign s_dx = 50'(p_cyx) - 50'(p_syz);
  assign s_t  = 50'(p_cyz) + 50'(p_syx);
  assign s_dy = r_spt + r_cpy;
  assign s_dz = r_cpt - r_spy;

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= 33'(vertex_x) - 33'(cam_x);
      y1    <= 33'(vertex_y) - 33'(cam_y);
      z1    <= 33'(vertex_z) - 33'(cam_z);

      p_cyx <= cy * x1;
      p_syz <= sy * z1;
      p_cyz <= cy * z1;
      p_syx <= sy * x1;
      y2    <= y1;

      dx3   <= s_dx[49:14];
      t3    <= s_t[49:14];
      y3    <= y2;

      r_spt <= sp * t3;
      r_cpy <= cp * y3;
      r_cpt <= cp * t3;
      r_spy <= sp * y3;
      dx4   <= dx3;

      dx    <= cpp_pkg::COORD_W'(dx4);
      dy    <= s_dy[51:14];
      dz    <= s_dz[51:14];
    end
  end

endmodule

/* rtl/cpp_mag_mul.sv */
// ----------------------------------------------------------------------------
// cpp_mag_mul - magnitudes and the wide numerator / denominator products
// Three stages: magnitude and signs, partial products, partial product sums.
// ----------------------------------------------------------------------------
module cpp_mag_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [cpp_pkg::COORD_W-1:0] dx,
  input  logic signed [cpp_pkg::COORD_W-1:0] dy,
  input  logic signed [cpp_pkg::COORD_W-1:0] dz,
  input  logic [cpp_pkg::SCALE_W-1:0]        scale_x,
  input  logic [cpp_pkg::SCALE_W-1:0]        scale_y,
  input  logic [cpp_pkg::VIEW_W-1:0]         view_w,
  input  logic [cpp_pkg::VIEW_W-1:0]         view_h,
  output logic [cpp_pkg::NUM_W-1:0]          num_x,
  output logic [cpp_pkg::NUM_W-1:0]          num_y,
  output logic [cpp_pkg::DEN_W-1:0]          den_x,
  output logic [cpp_pkg::DEN_W-1:0]          den_y,
  output cpp_pkg::side_t                     side
);

  localparam int CW = cpp_pkg::COORD_W;
  localparam int ML = cpp_pkg::MAG_LO;
  localparam int SL = cpp_pkg::SCALE_LO;
  localparam int VL = cpp_pkg::VIEW_LO;
  localparam int NW = cpp_pkg::NUM_W;
  localparam int DW = cpp_pkg::DEN_W;

  logic [CW-1:0] mx, my, mz;
  cpp_pkg::side_t side6, side7;

  logic [40:0] pnx00, pnx01, pnx10, pnx11;
  logic [40:0] pny00, pny01, pny10, pny11;
  logic [34:0] pdx00, pdx01, pdx10, pdx11;
  logic [34:0] pdy00, pdy01, pdy10, pdy11;

  logic [cpp_pkg::VIEW_W-1:0] vw_eff, vh_eff;

  // a zero view size is treated as the raw value 1
  assign vw_eff = (view_w == '0) ? cpp_pkg::VIEW_W'(1) : view_w;
  assign vh_eff = (view_h == '0) ? cpp_pkg::VIEW_W'(1) : view_h;

  always_ff @(posedge clk) begin
    if (en) begin
      mx            <= dx[CW-1] ? CW'(-dx) : CW'(dx);
      my            <= dy[CW-1] ? CW'(-dy) : CW'(dy);
      mz            <= dz[CW-1] ? CW'(-dz) : CW'(dz);
      side6.pos_x   <= (dx[CW-1] == dz[CW-1]);
      side6.pos_y   <= (dy[CW-1] != dz[CW-1]);
      side6.dz_zero <= (dz == '0);
      side6.dz_neg  <= dz[CW-1];

      pnx00 <= mx[ML-1:0]  * scale_x[SL-1:0];
      pnx01 <= mx[ML-1:0]  * scale_x[cpp_pkg::SCALE_W-1:SL];
      pnx10 <= mx[CW-1:ML] * scale_x[SL-1:0];
      pnx11 <= mx[CW-1:ML] * scale_x[cpp_pkg::SCALE_W-1:SL];
      pny00 <= my[ML-1:0]  * scale_y[SL-1:0];
      pny01 <= my[ML-1:0]  * scale_y[cpp_pkg::SCALE_W-1:SL];
      pny10 <= my[CW-1:ML] * scale_y[SL-1:0];
      pny11 <= my[CW-1:ML] * scale_y[cpp_pkg::SCALE_W-1:SL];
      pdx00 <= mz[ML-1:0]  * vw_eff[VL-1:0];
      pdx01 <= mz[ML-1:0]  * vw_eff[cpp_pkg::VIEW_W-1:VL];
      pdx10 <= mz[CW-1:ML] * vw_eff[VL-1:0];
      pdx11 <= mz[CW-1:ML] * vw_eff[cpp_pkg::VIEW_W-1:VL];
      pdy00 <= mz[ML-1:0]  * vh_eff[VL-1:0];
      pdy01 <= mz[ML-1:0]  * vh_eff[cpp_pkg::VIEW_W-1:VL];
      pdy10 <= mz[CW-1:ML] * vh_eff[VL-1:0];
      pdy11 <= mz[CW-1:ML] * vh_eff[cpp_pkg::VIEW_W-1:VL];
      side7 <= side6;

      num_x <= NW'(pnx00) + (NW'(pnx01) << SL) + (NW'(pnx10) << ML)
             + (NW'(pnx11) << (SL + ML));
      num_y <= NW'(pny00) + (NW'(pny01) << SL) + (NW'(pny10) << ML)
             + (NW'(pny11) << (SL + ML));
      den_x <= DW'(pdx00) + (DW'(pdx01) << VL) + (DW'(pdx10) << ML)
             + (DW'(pdx11) << (VL + ML));
      den_y <= DW'(pdy00) + (DW'(pdy01) << VL) + (DW'(pdy10) << ML)
             + (DW'(pdy11) << (VL + ML));
      side  <= side7;
    end
  end

endmodule

/* rtl/cpp_div.sv */
// ----------------------------------------------------------------------------
// cpp_div - pipelined restoring divider, one quotient bit per stage
// First stage flags quotients of 2^Q_W or more; the rest resolve Q_W bits.
// ----------------------------------------------------------------------------
module cpp_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [cpp_pkg::NUM_W-1:0] num,
  input  logic [cpp_pkg::DEN_W-1:0] den,
  output logic [cpp_pkg::Q_W-1:0]   q,
  output logic                      ovf,
  output logic                      rem_nz
);

  localparam int NW = cpp_pkg::NUM_W;
  localparam int QW = cpp_pkg::Q_W;
  localparam int CW = cpp_pkg::CMP_W;

  logic [NW-1:0]           rem [QW+1];
  logic [cpp_pkg::DEN_W-1:0] dn [QW];
  logic [QW-1:0]           qq  [QW+1];
  logic                    ov  [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dn[0]  <= den;
      qq[0]  <= '0;
      ov[0]  <= CW'(num) >= {den, QW'(0)};
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    localparam int B = QW - 1 - i;
    logic [CW-1:0] trial;
    logic          take;

    assign trial = CW'(dn[i]) << B;
    assign take  = CW'(rem[i]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]    <= take ? NW'(CW'(rem[i]) - trial) : rem[i];
        qq[i+1]     <= qq[i] | (QW'(take) << B);
        ov[i+1]     <= ov[i];
      end
    end

    if (i + 1 < QW) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          dn[i+1] <= dn[i];
        end
      end
    end
  end

  assign q      = qq[QW];
  assign ovf    = ov[QW];
  assign rem_nz = |rem[QW];

endmodule

/* rtl/camera_perspective_projection_top.sv */
// ----------------------------------------------------------------------------
// camera_perspective_projection_top - vertex to screen pixel projection
// Throughput: one request per cycle unless the result stalls, set by the
//   fully pipelined datapath (5 rotate stages, 3 multiply stages,
//   23 divider stages, 1 output stage).
// Reset: clears the pipeline valid bits and loads the default camera
//   (origin, no rotation, unit view plane and focal length).
// ----------------------------------------------------------------------------
//
// Data path:
//   cpp_rotate   translate by -camera, rotate yaw then pitch (Q2.14 trig)
//   cpp_mag_mul  |d| * res * focal  and  |dz| * view, split in 4 partials
//   cpp_div      two restoring dividers, one quotient bit per stage
//   output stage add to centre with truncation toward zero, saturate
//
// The whole pipeline advances together; it holds only when the result
// register is full and the consumer stalls. Configuration is read live by
// the stages, so writes are taken only while the pipe is empty and no
// request is on offer.
module camera_perspective_projection_top #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                              clk,
  input  logic                              rst,
  // vertex request
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [31:0]                vertex_x,
  input  logic signed [31:0]                vertex_y,
  input  logic signed [31:0]                vertex_z,
  // result
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [15:0]                screen_x,
  output logic signed [15:0]                screen_y,
  output logic [1:0]                        depth_status,
  output logic                              clipped,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                       cfg_data
);

  localparam int LAT = cpp_pkg::PIPE_LAT;
  localparam int SW  = cpp_pkg::SCALE_W;
  localparam int VW  = cpp_pkg::VIEW_W;

  localparam logic [cpp_pkg::RES_W-1:0] RES_X  = cpp_pkg::RES_W'(SCREEN_WIDTH);
  localparam logic [cpp_pkg::RES_W-1:0] RES_Y  = cpp_pkg::RES_W'(SCREEN_HEIGHT);
  localparam logic [cpp_pkg::RES_W-1:0] HALF_X = cpp_pkg::RES_W'(SCREEN_WIDTH / 2);
  localparam logic [cpp_pkg::RES_W-1:0] HALF_Y = cpp_pkg::RES_W'(SCREEN_HEIGHT / 2);

  typedef struct packed {
    logic [15:0] value;
    logic        clip;
  } axis_res_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [63:0]        trig;
  logic [VW-1:0]      view_w, view_h, focal;
  logic [SW-1:0]      scale_x, scale_y;

  // --------------------------------------------------------------------------
  // Pipeline control: one enable for every stage
  // --------------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld;

  // writes only land on an empty pipe with no request waiting
  assign cfg_ready = !(|vld) && !in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x  <= '0;
      cam_y  <= '0;
      cam_z  <= '0;
      trig   <= 64'h0000_4000_0000_4000;
      view_w <= VW'(32'd65536);
      view_h <= VW'(32'd65536);
      focal  <= VW'(32'd65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cpp_pkg::CFG_CAM_X:  cam_x  <= cfg_data[31:0];
        cpp_pkg::CFG_CAM_Y:  cam_y  <= cfg_data[31:0];
        cpp_pkg::CFG_CAM_Z:  cam_z  <= cfg_data[31:0];
        cpp_pkg::CFG_TRIG:   trig   <= cfg_data;
        cpp_pkg::CFG_VIEW_W: view_w <= cfg_data[VW-1:0];
        cpp_pkg::CFG_VIEW_H: view_h <= cfg_data[VW-1:0];
        cpp_pkg::CFG_FOCAL:  focal  <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  // resolution * focal length, follows focal in the next cycle
  always_ff @(posedge clk) begin
    scale_x <= SW'(focal) * SW'(RES_X);
    scale_y <= SW'(focal) * SW'(RES_Y);
  end

  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Data path
  // --------------------------------------------------------------------------
  logic signed [cpp_pkg::COORD_W-1:0] dx, dy, dz;
  logic [cpp_pkg::NUM_W-1:0]          num_x, num_y;
  logic [cpp_pkg::DEN_W-1:0]          den_x, den_y;
  cpp_pkg::side_t                     side8;
  cpp_pkg::side_t                     side_pipe [cpp_pkg::DIV_LAT];
  logic [cpp_pkg::Q_W-1:0]            q_x, q_y;
  logic                               ovf_x, ovf_y, rnz_x, rnz_y;

  cpp_rotate u_rotate (
    .clk      (clk),
    .en       (en),
    .vertex_x (vertex_x),
    .vertex_y (vertex_y),
    .vertex_z (vertex_z),
    .cam_x    (cam_x),
    .cam_y    (cam_y),
    .cam_z    (cam_z),
    .trig     (trig),
    .dx       (dx),
    .dy       (dy),
    .dz       (dz)
  );

  cpp_mag_mul u_mag_mul (
    .clk     (clk),
    .en      (en),
    .dx      (dx),
    .dy      (dy),
    .dz      (dz),
    .scale_x (scale_x),
    .scale_y (scale_y),
    .view_w  (view_w),
    .view_h  (view_h),
    .num_x   (num_x),
    .num_y   (num_y),
    .den_x   (den_x),
    .den_y   (den_y),
    .side    (side8)
  );

  cpp_div u_div_x (
    .clk    (clk),
    .en     (en),
    .num    (num_x),
    .den    (den_x),
    .q      (q_x),
    .ovf    (ovf_x),
    .rem_nz (rnz_x)
  );

  cpp_div u_div_y (
    .clk    (clk),
    .en     (en),
    .num    (num_y),
    .den    (den_y),
    .q      (q_y),
    .ovf    (ovf_y),
    .rem_nz (rnz_y)
  );

  // signs and depth flags ride alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      side_pipe[0] <= side8;
      for (int k = 1; k < cpp_pkg::DIV_LAT; k++) begin
        side_pipe[k] <= side_pipe[k-1];
      end
    end
  end

  // centre +/- quotient; the whole sum truncates toward zero, so a
  // negative offset with a remainder moves one further unless the sum
  // already sits at or below zero
  function automatic axis_res_t axis_final(
    input logic [cpp_pkg::Q_W-1:0]   q,
    input logic                      ovf,
    input logic                      rem_nz,
    input logic                      pos,
    input logic [cpp_pkg::RES_W-1:0] half
  );
    axis_res_t          r;
    logic signed [23:0] h, qi, v;
    h  = 24'(half);
    qi = 24'(q);
    r.clip = 1'b0;
    if (ovf || q > cpp_pkg::QLIMIT) begin
      r.clip  = 1'b1;
      r.value = pos ? 16'h7fff : 16'h8000;
    end else begin
      if (pos || q == '0) begin
        v = h + qi;
      end else if (!rem_nz || (h - qi) <= 24'sd0) begin
        v = h - qi;
      end else begin
        v = h - qi - 24'sd1;
      end
      if (v > 24'sd32767) begin
        r.clip  = 1'b1;
        r.value = 16'h7fff;
      end else if (v < -24'sd32768) begin
        r.clip  = 1'b1;
        r.value = 16'h8000;
      end else begin
        r.value = v[15:0];
      end
    end
    return r;
  endfunction

  cpp_pkg::side_t side_end;
  axis_res_t      res_x, res_y;

  assign side_end = side_pipe[cpp_pkg::DIV_LAT-1];
  assign res_x = axis_final(q_x, ovf_x, rnz_x, side_end.pos_x, HALF_X);
  assign res_y = axis_final(q_y, ovf_y, rnz_y, side_end.pos_y, HALF_Y);

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      if (side_end.dz_zero) begin
        screen_x     <= 16'(HALF_X);
        screen_y     <= 16'(HALF_Y);
        depth_status <= cpp_pkg::ST_ZERO;
        clipped      <= 1'b0;
      end else begin
        screen_x     <= res_x.value;
        screen_y     <= res_y.value;
        depth_status <= side_end.dz_neg ? cpp_pkg::ST_BEHIND : cpp_pkg::ST_FRONT;
        clipped      <= res_x.clip | res_y.clip;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a held result freezes every stage's valid bit
  a_hold_freezes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(vld))
    else $error("pipeline moved while result stalled");

  // zero depth never reports clipping and lands on the centre
  a_zero_centre: assert property (@(posedge clk) disable iff (rst)
    (out_valid && depth_status == cpp_pkg::ST_ZERO) |->
      (!clipped && screen_x == 16'(HALF_X) && screen_y == 16'(HALF_Y)))
    else $error("zero depth result not at centre");

  // requests are refused only while a result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

endmodule
